FILE: rtl/core/mwcs_pkg.sv
// Package for the minimum window cover search core.
// Holds sizes, memory request types and the controller state type.
// No dependencies.
`default_nettype none

package mwcs_pkg;

    localparam int MAX_TEXT    = 1024;
    localparam int MAX_PATTERN = 1024;
    localparam int ALPHABET    = 256;

    localparam int TEXT_AW  = $clog2(MAX_TEXT);
    localparam int POS_W    = TEXT_AW + 1;
    localparam int PLEN_W   = $clog2(MAX_PATTERN) + 1;
    localparam int SYM_W    = $clog2(ALPHABET);
    localparam int NEED_W   = ((PLEN_W > POS_W) ? PLEN_W : POS_W) + 1;
    localparam int START_W  = 10;
    localparam int LENGTH_W = 11;

    typedef logic signed [NEED_W-1:0] need_count_t;

    typedef struct packed {
        logic             rd_en;
        logic [SYM_W-1:0] rd_addr;
        logic             wr_en;
        logic [SYM_W-1:0] wr_addr;
        need_count_t      wr_data;
        logic             clear;
    } need_req_t;

    typedef struct packed {
        logic               rd_en;
        logic [TEXT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [TEXT_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } text_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT_UPD,
        ST_TXT_UPD,
        ST_SHR_CHK,
        ST_SHR_TXT,
        ST_SHR_UPD,
        ST_EMIT
    } ctrl_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/min_window_cover_search_core.sv
// Minimum window cover search core: shortest text window that holds all pattern bytes.
// Pattern byte: one count read-modify-write. Text byte: one count read-modify-write and a check;
// each byte dropped from the window's left edge adds a text read and a count read-modify-write.
// Only one item is in work at a time; the need table read-modify-write loop sets the rate.
// The result of a final text byte is registered in the emit state and is held until taken.
// Reset is synchronous, active low; the need table is cleared through its valid bits, no pass.
`default_nettype none

module min_window_cover_search_core
    import mwcs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_op,
    input  wire logic [7:0]          s_ch,
    input  wire logic                s_last,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_found,
    output logic [START_W-1:0]       m_win_start,
    output logic [LENGTH_W-1:0]      m_win_length,
    output logic                     m_overflow
);

    need_req_t   need_req;
    need_count_t need_rdata;
    text_req_t   text_req;
    logic [7:0]  text_rdata;

    mwcs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_ch         (s_ch),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_win_start  (m_win_start),
        .m_win_length (m_win_length),
        .m_overflow   (m_overflow),
        .need_req     (need_req),
        .need_rdata   (need_rdata),
        .text_req     (text_req),
        .text_rdata   (text_rdata)
    );

    mwcs_need_mem u_need_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (need_req),
        .rdata   (need_rdata)
    );

    mwcs_text_mem u_text_mem (
        .aclk  (aclk),
        .req   (text_req),
        .rdata (text_rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mwcs_need_mem.sv
// Need count table: one signed count per byte value, with a registered read.
// Per-entry valid bits make a cleared entry read as zero; depends on mwcs_pkg.
`default_nettype none

module mwcs_need_mem
    import mwcs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire need_req_t  req,
    output need_count_t     rdata
);

    need_count_t         mem [ALPHABET];
    logic [ALPHABET-1:0] valid_reg;
    need_count_t         rdata_raw_reg;
    logic                rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_raw_reg <= mem[req.rd_addr];
            rvalid_reg    <= valid_reg[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rdata = rvalid_reg ? rdata_raw_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/core/mwcs_text_mem.sv
// Text buffer: one byte per text position, with a registered read.
// Depends on mwcs_pkg.
`default_nettype none

module mwcs_text_mem
    import mwcs_pkg::*;
(
    input  wire logic       aclk,
    input  wire text_req_t  req,
    output logic [7:0]      rdata
);

    logic [7:0] mem [MAX_TEXT];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mwcs_ctrl.sv
// Sequencer of the window search: loads the pattern, advances the window and
// drives the two memories and the result register; depends on mwcs_pkg.
`default_nettype none

module mwcs_ctrl
    import mwcs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_op,
    input  wire logic [7:0]          s_ch,
    input  wire logic                s_last,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_found,
    output logic [START_W-1:0]       m_win_start,
    output logic [LENGTH_W-1:0]      m_win_length,
    output logic                     m_overflow,
    output need_req_t                need_req,
    input  wire need_count_t         need_rdata,
    output text_req_t                text_req,
    input  wire logic [7:0]          text_rdata
);

    ctrl_state_t          state_reg, state_next;
    logic [SYM_W-1:0]     c_reg, c_next;
    logic                 last_reg, last_next;
    logic [POS_W-1:0]     missing_reg, missing_next;
    logic [PLEN_W-1:0]    plen_reg, plen_next;
    logic [POS_W-1:0]     left_reg, left_next;
    logic [POS_W-1:0]     right_reg, right_next;
    logic [START_W-1:0]   best_start_reg, best_start_next;
    logic [LENGTH_W-1:0]  best_len_reg, best_len_next;
    logic                 ovf_reg, ovf_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 found_reg, found_next;
    logic [START_W-1:0]   start_reg, start_next;
    logic [LENGTH_W-1:0]  length_reg, length_next;
    logic                 out_ovf_reg, out_ovf_next;
    logic [POS_W-1:0]     win_len;
    need_count_t          need_inc;

    assign win_len  = right_reg - left_reg;
    assign need_inc = need_rdata + need_count_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            missing_reg    <= '0;
            plen_reg       <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            missing_reg    <= missing_next;
            plen_reg       <= plen_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg       <= c_next;
        last_reg    <= last_next;
        found_reg   <= found_next;
        start_reg   <= start_next;
        length_reg  <= length_next;
        out_ovf_reg <= out_ovf_next;
    end

    always_comb begin
        state_next      = state_reg;
        c_next          = c_reg;
        last_next       = last_reg;
        missing_next    = missing_reg;
        plen_next       = plen_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        found_next      = found_reg;
        start_next      = start_reg;
        length_next     = length_reg;
        out_ovf_next    = out_ovf_reg;
        need_req        = '0;
        text_req        = '0;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    c_next    = s_ch[SYM_W-1:0];
                    last_next = s_last;
                    if (!s_op) begin
                        if (right_reg != '0) begin
                            state_next = ST_IDLE;
                        end else if (plen_reg >= PLEN_W'(MAX_PATTERN)) begin
                            ovf_next = 1'b1;
                        end else begin
                            need_req.rd_en   = 1'b1;
                            need_req.rd_addr = s_ch[SYM_W-1:0];
                            state_next       = ST_PAT_UPD;
                        end
                    end else if (right_reg >= POS_W'(MAX_TEXT)) begin
                        ovf_next   = 1'b1;
                        state_next = s_last ? ST_EMIT : ST_IDLE;
                    end else begin
                        text_req.wr_en   = 1'b1;
                        text_req.wr_addr = right_reg[TEXT_AW-1:0];
                        text_req.wr_data = s_ch;
                        need_req.rd_en   = 1'b1;
                        need_req.rd_addr = s_ch[SYM_W-1:0];
                        state_next       = ST_TXT_UPD;
                    end
                end
            end
            ST_PAT_UPD: begin
                need_req.wr_en   = 1'b1;
                need_req.wr_addr = c_reg;
                need_req.wr_data = need_inc;
                missing_next     = missing_reg + POS_W'(1);
                plen_next        = plen_reg + PLEN_W'(1);
                state_next       = ST_IDLE;
            end
            ST_TXT_UPD: begin
                need_req.wr_en   = 1'b1;
                need_req.wr_addr = c_reg;
                need_req.wr_data = need_rdata - need_count_t'(1);
                if (need_rdata > need_count_t'(0)) begin
                    missing_next = missing_reg - POS_W'(1);
                end
                right_next = right_reg + POS_W'(1);
                if (plen_reg != '0) begin
                    state_next = ST_SHR_CHK;
                end else begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_SHR_CHK: begin
                if (missing_reg == '0 && left_reg < right_reg) begin
                    if (best_len_reg == '0 || LENGTH_W'(win_len) < best_len_reg) begin
                        best_start_next = left_reg[START_W-1:0];
                        best_len_next   = LENGTH_W'(win_len);
                    end
                    text_req.rd_en   = 1'b1;
                    text_req.rd_addr = left_reg[TEXT_AW-1:0];
                    state_next       = ST_SHR_TXT;
                end else begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_SHR_TXT: begin
                c_next           = text_rdata[SYM_W-1:0];
                need_req.rd_en   = 1'b1;
                need_req.rd_addr = text_rdata[SYM_W-1:0];
                state_next       = ST_SHR_UPD;
            end
            ST_SHR_UPD: begin
                need_req.wr_en   = 1'b1;
                need_req.wr_addr = c_reg;
                need_req.wr_data = need_inc;
                if (need_inc > need_count_t'(0)) begin
                    missing_next = missing_reg + POS_W'(1);
                end
                left_next  = left_reg + POS_W'(1);
                state_next = ST_SHR_CHK;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    found_next      = (best_len_reg != '0);
                    start_next      = best_start_reg;
                    length_next     = best_len_reg;
                    out_ovf_next    = ovf_reg;
                    need_req.clear  = 1'b1;
                    missing_next    = '0;
                    plen_next       = '0;
                    left_next       = '0;
                    right_next      = '0;
                    best_start_next = '0;
                    best_len_next   = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = found_reg;
    assign m_win_start  = start_reg;
    assign m_win_length = length_reg;
    assign m_overflow   = out_ovf_reg;

    a_left_not_past_right: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= right_reg)
        else $error("Window left edge passed the right edge.");

    a_missing_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        POS_W'(missing_reg) <= POS_W'(plen_reg))
        else $error("Missing count exceeds pattern length.");

    a_best_within_text: assert property (@(posedge aclk) disable iff (!aresetn)
        POS_W'(best_len_reg) <= right_reg)
        else $error("Best window longer than the scanned text.");

    a_emit_clears_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!m_valid_reg || m_ready))
        |=> (right_reg == '0 && plen_reg == '0 && m_valid_reg))
        else $error("Job state not cleared after result transfer was loaded.");

endmodule

`default_nettype wire
